// ----- rtl/esd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character constants and decode helpers for the escape sequence
// decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3
    } esd_phase_t;

    typedef enum logic [1:0] {
        ESC_KNOWN = 2'd0,
        ESC_HEX   = 2'd1,
        ESC_BAD   = 2'd2
    } esd_esc_kind_t;

    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_UZ        = 8'h5A;
    localparam logic [7:0] CH_LX        = 8'h78;
    localparam logic [7:0] CH_LB        = 8'h62;
    localparam logic [7:0] CH_LN        = 8'h6E;
    localparam logic [7:0] CH_LR        = 8'h72;
    localparam logic [7:0] CH_LT        = 8'h74;
    localparam logic [7:0] CH_LV        = 8'h76;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] DIGIT_TEN    = 8'd10;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } esd_digit_t;

    typedef struct packed {
        esd_esc_kind_t kind;
        logic [7:0]    value;
    } esd_esc_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_end;
        logic       out_error;
    } esd_result_t;

    typedef struct packed {
        esd_phase_t phase;
        logic [3:0] high_nibble;
        logic       failed;
    } esd_state_t;

    function automatic esd_digit_t hex_digit(input logic [7:0] b);
        esd_digit_t d;
        logic [7:0] t;
        d = '{ok: 1'b0, value: 4'd0};
        t = 8'd0;
        if (b >= CH_0 && b <= CH_9)
        begin
            t = b - CH_0;
            d.ok = 1'b1;
        end
        else if (b >= CH_LA && b <= CH_LF)
        begin
            t = b - CH_LA + DIGIT_TEN;
            d.ok = 1'b1;
        end
        else if (b >= CH_UA && b <= CH_UF)
        begin
            t = b - CH_UA + DIGIT_TEN;
            d.ok = 1'b1;
        end
        d.value = t[3:0];
        return d;
    endfunction

    function automatic esd_esc_t escape_map(input logic [7:0] b);
        esd_esc_t   e;
        logic [7:0] lc;
        lc = b;
        if (b >= CH_UA && b <= CH_UZ)
        begin
            lc = b + CASE_OFFSET;
        end
        e = '{kind: ESC_KNOWN, value: 8'h00};
        case (lc)
            CH_QUOTE:     e.value = 8'h27;
            CH_DQUOTE:    e.value = 8'h22;
            CH_BACKSLASH: e.value = 8'h5C;
            CH_0:         e.value = 8'h00;
            CH_LA:        e.value = 8'h07;
            CH_LB:        e.value = 8'h08;
            CH_LF:        e.value = 8'h0C;
            CH_LN:        e.value = 8'h0A;
            CH_LR:        e.value = 8'h0D;
            CH_LT:        e.value = 8'h09;
            CH_LV:        e.value = 8'h0B;
            CH_LX:        e.kind  = ESC_HEX;
            default:      e.kind  = ESC_BAD;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/esd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_in_if
// Raw byte channel: valid/ready handshake carrying one string byte per beat.
// ----------------------------------------------------------------------------
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/esd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_out_if
// Decoded result channel: valid/ready handshake, one result per beat.
// ----------------------------------------------------------------------------
interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
    logic       out_error;

    modport source (output valid, output out_byte, output out_valid,
                    output out_end, output out_error, input ready);
    modport sink   (input valid, input out_byte, input out_valid,
                    input out_end, input out_error, output ready);
endinterface
`default_nettype wire

// ----- rtl/esd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_decode
// Per-byte decode: next decoder state and the result for one raw byte.
// ----------------------------------------------------------------------------
module esd_decode
    import esd_pkg::*;
(
    input  esd_state_t  state,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output esd_state_t  state_next,
    output esd_result_t result,
    output logic        emit
);

    esd_digit_t dig;
    esd_esc_t   esc;
    logic       have;
    logic [7:0] val;
    esd_state_t st;

    assign dig = hex_digit(in_byte);
    assign esc = escape_map(in_byte);

    always_comb
    begin
        st   = state;
        have = 1'b0;
        val  = 8'h00;
        if (!state.failed)
        begin
            case (state.phase)
                PH_ESC:
                begin
                    case (esc.kind)
                        ESC_HEX:   st.phase = PH_HEX1;
                        ESC_KNOWN:
                        begin
                            val      = esc.value;
                            have     = 1'b1;
                            st.phase = PH_PLAIN;
                        end
                        default:   st.failed = 1'b1;
                    endcase
                end
                PH_HEX1:
                begin
                    if (dig.ok)
                    begin
                        st.high_nibble = dig.value;
                        st.phase       = PH_HEX2;
                    end
                    else
                    begin
                        st.failed = 1'b1;
                    end
                end
                PH_HEX2:
                begin
                    if (dig.ok)
                    begin
                        val      = {state.high_nibble, dig.value};
                        have     = 1'b1;
                        st.phase = PH_PLAIN;
                    end
                    else
                    begin
                        st.failed = 1'b1;
                    end
                end
                default:
                begin
                    if (in_byte == CH_BACKSLASH)
                    begin
                        st.phase = PH_ESC;
                    end
                    else
                    begin
                        val      = in_byte;
                        have     = 1'b1;
                        st.phase = PH_PLAIN;
                    end
                end
            endcase
            // an escape left open at the end of the string is malformed
            if (in_last && st.phase != PH_PLAIN)
            begin
                st.failed = 1'b1;
            end
        end
    end

    always_comb
    begin
        emit             = in_last || have;
        result.out_end   = in_last;
        result.out_error = in_last && st.failed;
        result.out_valid = have && !(in_last && st.failed);
        result.out_byte  = result.out_valid ? val : 8'h00;
        if (in_last)
        begin
            state_next = '{phase: PH_PLAIN, high_nibble: 4'd0, failed: 1'b0};
        end
        else
        begin
            state_next = st;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/escape_sequence_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming decoder for C-style string escapes, one raw byte per beat.
// ----------------------------------------------------------------------------
// One raw byte is taken per clock cycle while the result register is empty or
// being drained in the same cycle; the decoder state and the escape lookup
// settle within that cycle, so a byte's result is on the output in the cycle
// after its beat and a new byte can follow on every cycle. Bytes that open or
// continue an escape produce no result unless they end the string. The beat
// with out_end closes each string; if out_error is set there, the consumer
// discards every byte it received for that string.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    esd_in_if.sink     raw,
    esd_out_if.source  decoded
);

    esd_state_t  state_reg;
    esd_state_t  state_next;
    esd_result_t result_reg;
    esd_result_t result_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        emit;
    logic        accept;

    esd_decode u_decode (
        .state      (state_reg),
        .in_byte    (raw.in_byte),
        .in_last    (raw.in_last),
        .state_next (state_next),
        .result     (result_next),
        .emit       (emit)
    );

    assign raw.ready = !res_valid_reg || decoded.ready;
    assign accept    = raw.valid && raw.ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (decoded.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (accept && emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_PLAIN, high_nibble: 4'd0, failed: 1'b0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    // hold payload until a new result is loaded
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign decoded.valid     = res_valid_reg;
    assign decoded.out_byte  = result_reg.out_byte;
    assign decoded.out_valid = result_reg.out_valid;
    assign decoded.out_end   = result_reg.out_end;
    assign decoded.out_error = result_reg.out_error;

endmodule
`default_nettype wire
